### hw/rtl/deq_pkg.sv
// Shared types, constants and ring index helpers for the double-ended queue.
// Used by the controller, datapath and top level; depends on nothing.
package deq_pkg;

  localparam int DEPTH  = 16;
  localparam int WORD_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OCC_W  = 5;

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic signed [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic accept;  // request taken this cycle
    logic finish;  // result loaded into the output register this cycle
  } deq_cmd_t;

  function automatic idx_t ring_next(idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t ring_prev(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

### hw/rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/deq_ctrl.sv
// Controller for the double-ended queue: request handshake, execute state
// and output valid. Depends on deq_pkg.
module deq_ctrl
  import deq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output deq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;
  logic   slot_free;

  assign slot_free  = !out_valid || !out_stall;
  assign cmd.accept = in_valid && !in_stall;
  assign cmd.finish = (state == S_EXEC) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_stall  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
          end
          if (cmd.accept) begin
            state    <= S_EXEC;
            in_stall <= 1'b1;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            state     <= S_IDLE;
            in_stall  <= 1'b0;
            out_valid <= 1'b1;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

### hw/rtl/deq_dpath.sv
// Datapath for the double-ended queue: ring indices, count, cached end words,
// entry RAM and result register. Depends on deq_pkg and deq_ram.
module deq_dpath
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  deq_cmd_t                 cmd,
  input  logic [1:0]               func,
  input  logic signed [WORD_W-1:0] push_value,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] popped_value,
  output logic signed [WORD_W-1:0] front_value,
  output logic signed [WORD_W-1:0] back_value,
  output logic [OCC_W-1:0]         occupancy
);

  idx_t    head;
  idx_t    tail;
  cnt_t    count;
  word_t   front_word;
  word_t   back_word;
  op_t     op;
  status_t st;
  word_t   popped_word;

  op_t     op_in;
  logic    empty;
  logic    full;
  logic    is_push;
  status_t st_in;
  logic    ok_in;
  logic    ram_we;
  idx_t    ram_waddr;
  logic    ram_re;
  idx_t    ram_raddr;
  word_t   rd_data;
  word_t   front_now;
  word_t   back_now;

  assign op_in   = op_t'(func);
  assign empty   = (count == '0);
  assign full    = (count == cnt_t'(DEPTH));
  assign is_push = (op_in == OP_PUSH_FRONT) || (op_in == OP_PUSH_BACK);

  always_comb begin
    if (is_push) begin
      st_in = full ? ST_OVERFLOW : ST_OK;
    end else begin
      st_in = empty ? ST_UNDERFLOW : ST_OK;
    end
  end

  assign ok_in     = (st_in == ST_OK);
  assign ram_we    = cmd.accept && ok_in && is_push;
  assign ram_waddr = (op_in == OP_PUSH_FRONT) ? ring_prev(head) : tail;
  // new end word is fetched only when the pop leaves something behind
  assign ram_re    = cmd.accept && ok_in && !is_push && (count > cnt_t'(1));
  assign ram_raddr = (op_in == OP_POP_FRONT) ? ring_next(head) : ring_prev(ring_prev(tail));

  deq_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(push_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign front_now = (op == OP_POP_FRONT && st == ST_OK) ? rd_data : front_word;
  assign back_now  = (op == OP_POP_BACK && st == ST_OK) ? rd_data : back_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.accept && ok_in) begin
      case (op_in)
        OP_PUSH_FRONT: begin
          head  <= ring_prev(head);
          count <= cnt_t'(count + 1'b1);
        end
        OP_PUSH_BACK: begin
          tail  <= ring_next(tail);
          count <= cnt_t'(count + 1'b1);
        end
        OP_POP_FRONT: begin
          head  <= ring_next(head);
          count <= cnt_t'(count - 1'b1);
        end
        OP_POP_BACK: begin
          tail  <= ring_prev(tail);
          count <= cnt_t'(count - 1'b1);
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op <= op_in;
      st <= st_in;
      if (!ok_in) begin
        popped_word <= '0;
      end else begin
        case (op_in)
          OP_PUSH_FRONT: begin
            popped_word <= '0;
            front_word  <= push_value;
            if (empty) begin
              back_word <= push_value;
            end
          end
          OP_PUSH_BACK: begin
            popped_word <= '0;
            back_word   <= push_value;
            if (empty) begin
              front_word <= push_value;
            end
          end
          OP_POP_FRONT: popped_word <= front_word;
          OP_POP_BACK:  popped_word <= back_word;
          default:      popped_word <= '0;
        endcase
      end
    end
    if (cmd.finish) begin
      front_word   <= front_now;
      back_word    <= back_now;
      status       <= st;
      popped_value <= popped_word;
      front_value  <= empty ? '1 : front_now;
      back_value   <= empty ? '1 : back_now;
      occupancy    <= OCC_W'(count);
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(DEPTH))
    else $error("word count above depth");

  a_ends_meet: assert property (@(posedge clk) disable iff (rst)
    (empty || full) |-> (head == tail))
    else $error("head and tail disagree with count");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !ok_in) |=> (count == $past(count) && head == $past(head)
                                && tail == $past(tail)))
    else $error("rejected request changed queue state");
`endif

endmodule

### hw/rtl/double_ended_queue.sv
// Top level of the double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl, deq_dpath and deq_ram.
//
// Ring of DEPTH signed 32-bit words (DEPTH = 16) with push and pop at either
// end. Every request gives exactly one result. A request first updates the
// indices and writes or reads the entry RAM, then loads the result register
// with the new end word from the RAM's registered read port. The input is
// taken again as soon as the result is loaded, so a new request proceeds
// while the previous result waits on out_stall. Pop on empty reports
// underflow, push on full reports overflow; neither changes the queue.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               func,
  input  logic signed [WORD_W-1:0] push_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic signed [WORD_W-1:0] popped_value,
  output logic signed [WORD_W-1:0] front_value,
  output logic signed [WORD_W-1:0] back_value,
  output logic [OCC_W-1:0]         occupancy
);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  deq_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .func        (func),
    .push_value  (push_value),
    .status      (status),
    .popped_value(popped_value),
    .front_value (front_value),
    .back_value  (back_value),
    .occupancy   (occupancy)
  );

endmodule
